>>> rtl/lrut_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrut_pkg: shared definitions for the lru replacement tracker
// Sizes, command and status codes, and the control bundle that steers the
// key store.
// ----------------------------------------------------------------------------
package lrut_pkg;

	// store geometry
	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 16;
	localparam int IDX_BITS = $clog2(ENTRIES);
	localparam int CNT_BITS = $clog2(ENTRIES + 1);

	// field widths at the ports
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	// command codes, code 3 is unused and does nothing
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_VICTIM = 2'd1,
		CMD_ERASE  = 2'd2
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// reorder operations on the recency list
	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_FRONT  = 2'd1,
		OP_REMOVE = 2'd2
	} store_op_t;

	// control bundle from the decision logic to the key store
	typedef struct packed {
		logic                wr;
		store_op_t           op;
		logic [IDX_BITS-1:0] pos;
	} store_ctl_t;

endpackage
`default_nettype wire

>>> rtl/lru_replacement_tracker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_replacement_tracker_unit: lru replacement tracker top level
// Input register, combinational decision over the key list, result register.
// ----------------------------------------------------------------------------
// The tracker keeps up to ENTRIES distinct keys in recency order and takes
// one item every clock cycle while the result side is not stalled: insert
// or touch a key, take the least recent key as victim, or erase a key. Each
// item is loaded into the input register at acceptance and moves into the
// result register when that is free or drains; the result carries the status,
// the victim key and the occupancy after the command. The rate is
// set by the combinational compare of the key against all stored positions
// plus the shift of the ordered register list; the list state is written
// as the item moves into the result register, so the next item sees it
// without a bubble. No clearing pass is needed after reset.
module lru_replacement_tracker_unit import lrut_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire logic [CMD_W-1:0]    command,
	input  wire logic [KEY_BITS-1:0] key,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic      [STATUS_W-1:0] status,
	output logic      [KEY_BITS-1:0] victim_key,
	output logic      [CNT_BITS-1:0] occupancy
);

	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic                advance;
	logic [CNT_BITS-1:0] used_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [KEY_BITS-1:0] victim_q;
	logic [CNT_BITS-1:0] occ_q;

	logic [ENTRIES-1:0]  hit;
	logic [KEY_BITS-1:0] tail_key;
	status_t             dec_status;
	logic [CNT_BITS-1:0] dec_used;
	logic [KEY_BITS-1:0] dec_victim;
	store_op_t           dec_op;
	logic [IDX_BITS-1:0] dec_pos;
	store_ctl_t          ctl;

	// handshake: stage 1 moves when the result register is free or drains
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !advance;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= command;
			key_s1 <= key;
		end
	end

	// key list and compare
	lrut_key_store u_store (
		.clk      (clk),
		.key      (key_s1),
		.used     (used_q),
		.ctl      (ctl),
		.hit      (hit),
		.tail_key (tail_key)
	);

	// command decision
	lrut_decide u_decide (
		.command    (cmd_s1),
		.used       (used_q),
		.hit        (hit),
		.tail_key   (tail_key),
		.status     (dec_status),
		.used_next  (dec_used),
		.victim_key (dec_victim),
		.op         (dec_op),
		.pos        (dec_pos)
	);

	// store write when the item leaves stage 1
	always_comb begin
		ctl.wr  = advance && valid_s1;
		ctl.op  = dec_op;
		ctl.pos = dec_pos;
	end

	// occupancy and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				used_q <= dec_used;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_q <= dec_status;
			victim_q <= dec_victim;
			occ_q    <= dec_used;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign victim_key = victim_q;
	assign occupancy  = occ_q;

	// occupancy never exceeds the store size
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_BITS'(ENTRIES))
		else $error("occupancy above store size");

	// a rejected insert only happens on a full store
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q == ST_FULL) |-> occ_q == CNT_BITS'(ENTRIES))
		else $error("full status with free entries");

	// occupancy holds unless an item moves out of stage 1
	a_used_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(used_q))
		else $error("occupancy changed without an item");

	// a delivered victim key means the list had an entry
	a_victim_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (victim_q != '0) |-> status_q == ST_OK)
		else $error("victim key with failing status");

endmodule
`default_nettype wire

>>> rtl/lrut_key_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrut_key_store: recency ordered key list
// Holds the keys, most recent at position 0, compares every valid position
// against the search key and shifts the list to move or drop one position.
// ----------------------------------------------------------------------------
module lrut_key_store import lrut_pkg::*; (
	input  wire logic                clk,
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic [CNT_BITS-1:0] used,
	input  wire store_ctl_t          ctl,
	output logic      [ENTRIES-1:0]  hit,
	output logic      [KEY_BITS-1:0] tail_key
);

	logic [KEY_BITS-1:0] keys_q [ENTRIES];
	logic [KEY_BITS-1:0] keys_d [ENTRIES];
	logic [CNT_BITS-1:0] tail_cnt;

	// parallel compare over the valid positions
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit[i] = (CNT_BITS'(i) < used) && (keys_q[i] == key);
		end
	end

	// least recent key sits at position used-1
	assign tail_cnt = used - CNT_BITS'(1);
	assign tail_key = keys_q[tail_cnt[IDX_BITS-1:0]];

	// next list: move to front or close a gap
	always_comb begin
		keys_d = keys_q;
		unique case (ctl.op)
			OP_FRONT: begin
				keys_d[0] = key;
				for (int i = 1; i < ENTRIES; i++) begin
					if (IDX_BITS'(i) <= ctl.pos) begin
						keys_d[i] = keys_q[i-1];
					end
				end
			end
			OP_REMOVE: begin
				for (int i = 0; i < ENTRIES - 1; i++) begin
					if (IDX_BITS'(i) >= ctl.pos) begin
						keys_d[i] = keys_q[i+1];
					end
				end
			end
			default: begin
				keys_d = keys_q;
			end
		endcase
	end

	// key registers, payload only
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			keys_q <= keys_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/lrut_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrut_decide: command decision logic
// Turns a command, the compare result and the occupancy into a status,
// the next occupancy, the victim key and the reorder for the key store.
// ----------------------------------------------------------------------------
module lrut_decide import lrut_pkg::*; (
	input  wire logic [CMD_W-1:0]    command,
	input  wire logic [CNT_BITS-1:0] used,
	input  wire logic [ENTRIES-1:0]  hit,
	input  wire logic [KEY_BITS-1:0] tail_key,
	output status_t                  status,
	output logic      [CNT_BITS-1:0] used_next,
	output logic      [KEY_BITS-1:0] victim_key,
	output store_op_t                op,
	output logic      [IDX_BITS-1:0] pos
);

	logic                any_hit;
	logic [IDX_BITS-1:0] hit_idx;

	// keys are distinct, so at most one position matches
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit[i]) begin
				hit_idx = hit_idx | IDX_BITS'(i);
			end
		end
	end
	assign any_hit = |hit;

	// per command outcome
	always_comb begin
		status     = ST_OK;
		used_next  = used;
		victim_key = '0;
		op         = OP_NONE;
		pos        = '0;
		unique case (cmd_t'(command))
			CMD_INSERT: begin
				if (any_hit) begin
					op  = OP_FRONT;
					pos = hit_idx;
				end else if (used < CNT_BITS'(ENTRIES)) begin
					op        = OP_FRONT;
					pos       = used[IDX_BITS-1:0];
					used_next = used + CNT_BITS'(1);
				end else begin
					status = ST_FULL;
				end
			end
			CMD_VICTIM: begin
				if (used == '0) begin
					status = ST_MISS;
				end else begin
					victim_key = tail_key;
					used_next  = used - CNT_BITS'(1);
				end
			end
			CMD_ERASE: begin
				if (any_hit) begin
					op        = OP_REMOVE;
					pos       = hit_idx;
					used_next = used - CNT_BITS'(1);
				end else begin
					status = ST_MISS;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: lru replacement tracker check
// Sends insert, victim, erase and unused commands over the valid/stall
// command channel and compares each response against an in-order
// recency-list predictor that is updated as each item is accepted.
// ----------------------------------------------------------------------------
module testbench;
	import lrut_pkg::*;

	localparam int          CLK_PERIOD   = 8;
	localparam int          RESET_CYCLES = 12;
	localparam int          LIMIT_CYCLES = 200000;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          RANDOM_ITEMS = 930;
	localparam int          POOL_SIZE    = 24;
	localparam int          MAX_REPORTS  = 10;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;

	// one queued command item
	typedef struct {
		logic [CMD_W-1:0]    cmd;
		logic [KEY_BITS-1:0] k;
		int unsigned         phase;
		bit                  drain;
	} cmd_item_t;

	// one predicted response
	typedef struct {
		logic [STATUS_W-1:0] st;
		logic [KEY_BITS-1:0] vkey;
		logic [CNT_BITS-1:0] occ;
	} lru_rsp_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cmd_valid  = 1'b0;
	logic                cmd_stall;
	logic [CMD_W-1:0]    command    = '0;
	logic [KEY_BITS-1:0] key        = '0;
	logic                rsp_valid;
	logic                rsp_stall  = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_BITS-1:0] victim_key;
	logic [CNT_BITS-1:0] occupancy;

	cmd_item_t   queued_cmds[$];
	lru_rsp_t    predicted_rsps[$];
	int unsigned cur_phase   = 0;
	int unsigned fail_count  = 0;
	int unsigned rsp_count   = 0;
	int unsigned cycle_count = 0;

	// predictor state: position 0 most recent
	logic [KEY_BITS-1:0] recency_list[ENTRIES];
	int unsigned         tracked_keys = 0;

	// idle and stall percentages for each phase
	int unsigned send_idle_pct[3] = '{35, 79, 0};
	int unsigned recv_stall_pct[3] = '{79, 35, 0};

	lru_replacement_tracker_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.command    (command),
		.key        (key),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.victim_key (victim_key),
		.occupancy  (occupancy)
	);

	// clock
	always #(CLK_PERIOD / 2) clk = ~clk;

	// position of a key in the tracked list, or -1
	function automatic int find_tracked(logic [KEY_BITS-1:0] k);
		for (int i = 0; i < tracked_keys; i++) begin
			if (recency_list[i] == k)
				return i;
		end
		return -1;
	endfunction

	// apply one command to the recency list and return the response it gives
	function automatic lru_rsp_t apply_lru_command(logic [CMD_W-1:0] cmd,
			logic [KEY_BITS-1:0] k);
		lru_rsp_t r;
		int       pos;
		r.st   = ST_OK;
		r.vkey = '0;
		case (cmd)
			CMD_INSERT: begin
				pos = find_tracked(k);
				if (pos < 0 && tracked_keys < ENTRIES) begin
					pos = tracked_keys;
					tracked_keys++;
				end
				if (pos < 0) begin
					r.st = ST_FULL;
				end else begin
					for (int i = pos; i > 0; i--)
						recency_list[i] = recency_list[i-1];
					recency_list[0] = k;
				end
			end
			CMD_VICTIM: begin
				if (tracked_keys == 0) begin
					r.st = ST_MISS;
				end else begin
					r.vkey = recency_list[tracked_keys-1];
					tracked_keys--;
				end
			end
			CMD_ERASE: begin
				pos = find_tracked(k);
				if (pos < 0) begin
					r.st = ST_MISS;
				end else begin
					for (int i = pos; i + 1 < tracked_keys; i++)
						recency_list[i] = recency_list[i+1];
					tracked_keys--;
				end
			end
			default: ;
		endcase
		r.occ = tracked_keys[CNT_BITS-1:0];
		return r;
	endfunction

	function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic [KEY_BITS-1:0] k,
			int unsigned phase, bit drain);
		cmd_item_t it;
		it.cmd   = cmd;
		it.k     = k;
		it.phase = phase;
		it.drain = drain;
		queued_cmds.push_back(it);
	endfunction

	// command driver: predict on accept, then present the next item
	always @(posedge clk) begin : drive_cmds
		cmd_item_t nxt;
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				predicted_rsps.push_back(apply_lru_command(command, key));
			if (!cmd_valid || !cmd_stall) begin
				if (queued_cmds.size() != 0
						&& !(queued_cmds[0].drain && predicted_rsps.size() != 0)
						&& $urandom_range(99) >= send_idle_pct[queued_cmds[0].phase]) begin
					nxt = queued_cmds.pop_front();
					cmd_valid <= 1'b1;
					command   <= nxt.cmd;
					key       <= nxt.k;
					cur_phase <= nxt.phase;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and random back-pressure
	always @(posedge clk) begin : check_rsps
		lru_rsp_t want;
		rsp_stall <= ($urandom_range(99) < recv_stall_pct[cur_phase]);
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_count++;
			if (predicted_rsps.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected response %0d: status %0d victim_key %h occupancy %0d",
						rsp_count, status, victim_key, occupancy);
			end else begin
				want = predicted_rsps.pop_front();
				if (status !== want.st || victim_key !== want.vkey
						|| occupancy !== want.occ) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display({"mismatch on response %0d (expected/actual): ",
							"status %0d/%0d victim_key %h/%h occupancy %0d/%0d"},
							rsp_count, want.st, status, want.vkey, victim_key,
							want.occ, occupancy);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("testbench failed");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
		logic [CMD_W-1:0]    c;
		logic [KEY_BITS-1:0] k;
		int unsigned         ins_pct;
		int unsigned         phase;
		int unsigned         r;

		// empty store: victim and erase miss, unused command does nothing
		queue_cmd(CMD_VICTIM, 16'h0000, 0, 1'b0);
		queue_cmd(CMD_ERASE, 16'h1234, 0, 1'b0);
		queue_cmd(CMD_UNUSED, 16'hFFFF, 0, 1'b0);
		// key extremes, then a touch of a present key
		queue_cmd(CMD_INSERT, 16'h0000, 0, 1'b0);
		queue_cmd(CMD_INSERT, 16'hFFFF, 0, 1'b0);
		queue_cmd(CMD_INSERT, 16'h0000, 0, 1'b0);
		// fill to capacity
		for (int i = 0; i < ENTRIES - 2; i++)
			queue_cmd(CMD_INSERT, KEY_BITS'(16'h0100 + i), 0, 1'b0);
		// full store: absent key rejected, present key still touched
		queue_cmd(CMD_INSERT, 16'hABCD, 0, 1'b0);
		queue_cmd(CMD_INSERT, 16'hFFFF, 0, 1'b0);
		queue_cmd(CMD_VICTIM, 16'h5555, 0, 1'b0);
		queue_cmd(CMD_ERASE, 16'h0105, 0, 1'b0);
		queue_cmd(CMD_ERASE, 16'hABCD, 0, 1'b0);
		queue_cmd(CMD_UNUSED, 16'h0000, 0, 1'b0);

		// random part: keys mostly from a small pool so hits and full stores happen
		ins_pct = 55;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			phase = (n * 3) / RANDOM_ITEMS;
			if (n == 0 || (n * 3) / RANDOM_ITEMS != ((n - 1) * 3) / RANDOM_ITEMS) begin
				for (int i = 0; i < POOL_SIZE; i++)
					key_pool[i] = KEY_BITS'($urandom_range(16'hFFFF));
			end
			if (n % 40 == 0)
				ins_pct = 30 + 25 * $urandom_range(2);
			r = $urandom_range(99);
			if (r < ins_pct) begin
				c = CMD_INSERT;
			end else begin
				r = $urandom_range(9);
				if (r < 4)
					c = CMD_VICTIM;
				else if (r < 9)
					c = CMD_ERASE;
				else
					c = CMD_UNUSED;
			end
			if ($urandom_range(99) < 85)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else
				k = KEY_BITS'($urandom_range(16'hFFFF));
			queue_cmd(c, k, phase,
				(n % (RANDOM_ITEMS / 3) == 0) || ($urandom_range(149) == 0));
		end

		// reset
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all items to be taken and answered
		while (queued_cmds.size() != 0 || cmd_valid || predicted_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && predicted_rsps.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

>>> files.f
rtl/lrut_pkg.sv
rtl/lrut_key_store.sv
rtl/lrut_decide.sv
rtl/lru_replacement_tracker_unit.sv
tb/sv/testbench.sv
